// File: hdl/dash_can_frame_scheduler_macros.svh
// assertion macros for the dash can frame scheduler
// used by the front, queue and back modules; expects clk and rst_n in scope
`ifndef DASH_CAN_FRAME_SCHEDULER_MACROS_SVH
`define DASH_CAN_FRAME_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define DCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define DCFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DCFS_ASSERT(lbl, prop, msg)
`define DCFS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: hdl/dcfs_pkg.sv
// shared types and constants of the dash can frame scheduler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dcfs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_RPM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_HOT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BULB_CHECK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 3'd6;

  localparam int DCFS_QUEUE_DEPTH = 2;

  // one bit per possible result of an event, in emission order
  localparam int NSLOT      = 11;
  localparam int SLOT_W     = $clog2(NSLOT);
  localparam int SLOT_SEQ   = 0;
  localparam int SLOT_BRST0 = 1;
  localparam int SLOT_BRST1 = 2;
  localparam int SLOT_BRST2 = 3;
  localparam int SLOT_BRST3 = 4;
  localparam int SLOT_210   = 5;
  localparam int SLOT_212   = 6;
  localparam int SLOT_308   = 7;
  localparam int SLOT_312   = 8;
  localparam int SLOT_416   = 9;
  localparam int SLOT_608   = 10;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_101_PRI,
    SEQ_111,
    SEQ_101_FF
  } seq_frame_t;

  // work handed from the front to the back for one event
  typedef struct packed {
    logic [NSLOT-1:0] mask;
    seq_frame_t       seq_kind;
    logic             running;
    logic             fan_hot;
    logic             lamp_210;
    logic [7:0]       b1_212;
    logic [7:0]       b5_212;
    logic [15:0]      rpm_code;
    logic [7:0]       b3_308;
    logic             b4_308;
    logic             ac;
    logic             brake;
    logic             asc;
    logic [7:0]       meter;
  } desc_t;

endpackage

// File: hdl/dcfs_front.sv
// front end: configuration registers, event state and classification
// depends on dcfs_pkg; pushes one desc_t per accepted beat into the queue
`timescale 1ns / 1ps
`include "dash_can_frame_scheduler_macros.svh"

module dcfs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dcfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic                           in_slot_20ms,
  input  logic                           in_slot_100ms,
  input  logic                           in_ignition_on,
  input  logic [15:0]                    in_engine_rpm,
  input  logic signed [12:0]             in_coolant_tenths,
  input  logic [10:0]                    in_rx_id,
  input  logic [3:0]                     in_rx_dlc,
  input  logic [7:0]                     in_rx_byte0,
  input  logic [7:0]                     in_rx_byte1,
  input  logic                           q_full,
  output logic                           q_push,
  output dcfs_pkg::desc_t                q_desc
);
  import dcfs_pkg::*;

  localparam logic [4:0] STEP_REF_PRI  = 5'd1;
  localparam logic [4:0] STEP_REF_111A = 5'd4;
  localparam logic [4:0] STEP_REF_FF   = 5'd5;
  localparam logic [4:0] STEP_REF_END  = 5'd8;
  localparam logic [4:0] STEP_INI_PRI  = 5'd10;
  localparam logic [4:0] STEP_INI_111A = 5'd13;
  localparam logic [4:0] STEP_INI_FF   = 5'd14;
  localparam logic [4:0] STEP_INI_END  = 5'd15;
  localparam logic [4:0] STEP_FIRST    = 5'd1;

  localparam logic [10:0] RX_ID_START = 11'h002;
  localparam logic [10:0] RX_ID_CLEAR = 11'h1E1;
  localparam logic [10:0] RX_ID_REQ   = 11'h2F1;
  localparam logic [10:0] RX_ID_BRAKE = 11'h200;
  localparam logic [10:0] RX_ID_ASC   = 11'h300;
  localparam logic [10:0] RX_ID_METER = 11'h412;
  localparam logic [10:0] RX_ID_AC    = 11'h443;

  localparam logic [23:0] RPM_RECIP   = 24'd8589935;
  localparam int          RPM_SHIFT   = 30;
  localparam logic [15:0] RPM_SAT_MIN = 16'd64000;

  // configuration
  logic [15:0]        running_rpm_r;
  logic signed [12:0] fan_hot_r;
  logic [15:0]        bulb_check_r;
  logic [15:0]        settle_r;
  logic [7:0]         burst_ticks_r;
  logic [7:0]         cooldown_ticks_r;
  logic [11:0]        repeat_ticks_r;

  // event state
  logic [15:0] ign_cnt_r, ign_cnt_nxt;
  logic [7:0]  burst_left_r, burst_left_nxt;
  logic [7:0]  cooldown_r, cooldown_nxt;
  logic [11:0] repeat_r, repeat_nxt;
  logic [4:0]  seq_step_r, seq_step_nxt;
  logic        seq_done_r, seq_done_nxt;
  logic        seq_refresh_r, seq_refresh_nxt;
  logic        ign_prev_r, ign_prev_nxt;
  logic        brake_r, brake_nxt;
  logic        ac_r, ac_nxt;
  logic        asc_r, asc_nxt;
  logic [7:0]  meter_r, meter_nxt;

  logic        accept;
  seq_frame_t  adv_kind;
  logic [4:0]  adv_step;
  logic        adv_done;
  logic        running;
  logic        fan_hot;
  logic [22:0] rpm_scaled;
  logic [46:0] rpm_prod;
  logic [15:0] rpm_code;
  logic [11:0] repeat_inc;
  logic        burst4;
  logic        burst3;
  logic        p20;
  logic        p100;
  logic        bulb_phase;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_rpm_r    <= 16'd400;
      fan_hot_r        <= 13'sd950;
      bulb_check_r     <= 16'd200;
      settle_r         <= 16'd250;
      burst_ticks_r    <= 8'd200;
      cooldown_ticks_r <= 8'd200;
      repeat_ticks_r   <= 12'd1500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RUNNING_RPM: running_rpm_r    <= cfg_data;
        CFG_FAN_HOT:     fan_hot_r        <= signed'(cfg_data[12:0]);
        CFG_BULB_CHECK:  bulb_check_r     <= cfg_data;
        CFG_SETTLE:      settle_r         <= cfg_data;
        CFG_BURST:       burst_ticks_r    <= cfg_data[7:0];
        CFG_COOLDOWN:    cooldown_ticks_r <= cfg_data[7:0];
        CFG_REPEAT:      repeat_ticks_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // rpm * 1.024 rounded: floor((128*rpm + 62) / 125) by reciprocal
  assign rpm_scaled = {in_engine_rpm, 7'd0} + 23'd62;
  assign rpm_prod   = 47'(rpm_scaled) * 47'(RPM_RECIP);
  assign rpm_code   = (in_engine_rpm >= RPM_SAT_MIN) ? 16'hFFFF : rpm_prod[RPM_SHIFT +: 16];

  assign running = in_engine_rpm > running_rpm_r;
  assign fan_hot = running || (in_coolant_tenths >= fan_hot_r);

  // one step of the init or refresh sequence on a tick
  always_comb begin
    adv_kind = SEQ_NONE;
    adv_step = seq_step_r;
    adv_done = seq_done_r;
    if (seq_step_r != '0) begin
      adv_step = seq_step_r + 5'd1;
      if (seq_refresh_r) begin
        case (seq_step_r)
          STEP_REF_PRI:  adv_kind = SEQ_101_PRI;
          STEP_REF_111A: adv_kind = SEQ_111;
          STEP_REF_FF:   adv_kind = SEQ_101_FF;
          STEP_REF_END: begin
            adv_kind = SEQ_111;
            adv_step = '0;
          end
          default: ;
        endcase
      end else begin
        case (seq_step_r)
          STEP_INI_PRI:  adv_kind = SEQ_101_PRI;
          STEP_INI_111A: adv_kind = SEQ_111;
          STEP_INI_FF:   adv_kind = SEQ_101_FF;
          STEP_INI_END: begin
            adv_kind = SEQ_111;
            adv_step = '0;
            adv_done = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    ign_cnt_nxt     = ign_cnt_r;
    burst_left_nxt  = burst_left_r;
    cooldown_nxt    = cooldown_r;
    repeat_nxt      = repeat_r;
    seq_step_nxt    = seq_step_r;
    seq_done_nxt    = seq_done_r;
    seq_refresh_nxt = seq_refresh_r;
    ign_prev_nxt    = ign_prev_r;
    brake_nxt       = brake_r;
    ac_nxt          = ac_r;
    asc_nxt         = asc_r;
    meter_nxt       = meter_r;
    repeat_inc      = (repeat_r == 12'hFFF) ? repeat_r : repeat_r + 12'd1;
    burst4          = 1'b0;
    burst3          = 1'b0;
    p20             = 1'b0;
    p100            = 1'b0;
    if (!in_func) begin
      seq_step_nxt = adv_step;
      seq_done_nxt = adv_done;
      burst4       = burst_left_r != '0;
      if (burst4) burst_left_nxt = burst_left_r - 8'd1;
      if (cooldown_r != '0) cooldown_nxt = cooldown_r - 8'd1;
      if (!in_ignition_on) begin
        if (ign_prev_r && adv_step == '0) seq_done_nxt = 1'b0;
        ign_prev_nxt = 1'b0;
        ign_cnt_nxt  = '0;
        repeat_nxt   = '0;
      end else begin
        if (!ign_prev_r && adv_step == '0) begin
          seq_step_nxt    = STEP_FIRST;
          seq_refresh_nxt = 1'b0;
        end
        ign_prev_nxt = 1'b1;
        if (in_slot_20ms) begin
          p20 = 1'b1;
          if (ign_cnt_r != 16'hFFFF) ign_cnt_nxt = ign_cnt_r + 16'd1;
          if (repeat_inc >= repeat_ticks_r) begin
            if (seq_step_nxt == '0) begin
              seq_step_nxt    = STEP_FIRST;
              seq_refresh_nxt = 1'b1;
            end
            repeat_nxt = '0;
          end else begin
            repeat_nxt = repeat_inc;
          end
        end
        p100 = in_slot_100ms;
      end
    end else begin
      if (in_rx_id == RX_ID_START && in_rx_dlc >= 4'd2 && in_rx_byte0 == 8'h00 &&
          in_rx_byte1 == 8'h00 && !seq_done_r && seq_step_r == '0) begin
        seq_step_nxt    = STEP_FIRST;
        seq_refresh_nxt = 1'b0;
      end
      if (in_rx_id == RX_ID_CLEAR && in_rx_dlc != 4'd0 && in_rx_byte0 == 8'h81) begin
        burst_left_nxt = burst_ticks_r;
        burst3         = 1'b1;
      end
      if (in_rx_id == RX_ID_REQ && in_rx_dlc >= 4'd2 && in_rx_byte0 == 8'h00 &&
          in_rx_byte1 == 8'h81 && cooldown_r == '0) begin
        cooldown_nxt = cooldown_ticks_r;
        burst3       = 1'b1;
      end
      if (in_rx_id == RX_ID_BRAKE && in_rx_dlc > 4'd1) begin
        brake_nxt = (in_rx_byte1 & 8'h05) == 8'h05;
      end else if (in_rx_id == RX_ID_ASC && in_rx_dlc != 4'd0) begin
        asc_nxt = in_rx_byte0[7];
      end else if (in_rx_id == RX_ID_METER && in_rx_dlc != 4'd0) begin
        meter_nxt = in_rx_byte0;
      end else if (in_rx_id == RX_ID_AC && in_rx_dlc != 4'd0) begin
        ac_nxt = in_rx_byte0[0];
      end
    end
  end

  assign bulb_phase = ign_cnt_nxt <= bulb_check_r;

  always_comb begin
    q_desc                  = '0;
    q_desc.seq_kind         = in_func ? SEQ_NONE : adv_kind;
    q_desc.mask[SLOT_SEQ]   = !in_func && adv_kind != SEQ_NONE;
    q_desc.mask[SLOT_BRST0] = burst3 || burst4;
    q_desc.mask[SLOT_BRST1] = burst3 || burst4;
    q_desc.mask[SLOT_BRST2] = burst3 || burst4;
    q_desc.mask[SLOT_BRST3] = burst4;
    q_desc.mask[SLOT_210]   = p20;
    q_desc.mask[SLOT_212]   = p20;
    q_desc.mask[SLOT_308]   = p20;
    q_desc.mask[SLOT_312]   = p20;
    q_desc.mask[SLOT_416]   = p100;
    q_desc.mask[SLOT_608]   = p100;
    q_desc.running          = running;
    q_desc.fan_hot          = fan_hot;
    q_desc.lamp_210         = !running && ign_cnt_nxt <= 16'd1;
    q_desc.rpm_code         = rpm_code;
    q_desc.b3_308           = running ? 8'h00 : (bulb_phase ? 8'h06 : 8'h04);
    q_desc.b4_308           = !running && (bulb_phase || ign_cnt_nxt <= settle_r);
    q_desc.ac               = ac_nxt;
    q_desc.brake            = brake_nxt;
    q_desc.asc              = asc_nxt;
    q_desc.meter            = meter_nxt;
    if (!running) begin
      q_desc.b1_212 = 8'h37;
      q_desc.b5_212 = 8'hDA;
    end else if (in_engine_rpm >= 16'd1500) begin
      q_desc.b1_212 = 8'h20;
      q_desc.b5_212 = 8'h2F;
    end else if (in_engine_rpm >= 16'd1200) begin
      q_desc.b1_212 = 8'h28;
      q_desc.b5_212 = 8'h31;
    end else if (in_engine_rpm >= 16'd1000) begin
      q_desc.b1_212 = 8'h37;
      q_desc.b5_212 = 8'h34;
    end else if (in_engine_rpm >= 16'd900) begin
      q_desc.b1_212 = 8'h37;
      q_desc.b5_212 = 8'h37;
    end else begin
      q_desc.b1_212 = 8'h37;
      q_desc.b5_212 = 8'h3A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_cnt_r     <= '0;
      burst_left_r  <= '0;
      cooldown_r    <= '0;
      repeat_r      <= '0;
      seq_step_r    <= '0;
      seq_done_r    <= 1'b0;
      seq_refresh_r <= 1'b0;
      ign_prev_r    <= 1'b0;
      brake_r       <= 1'b0;
      ac_r          <= 1'b0;
      asc_r         <= 1'b0;
      meter_r       <= '0;
    end else if (accept) begin
      ign_cnt_r     <= ign_cnt_nxt;
      burst_left_r  <= burst_left_nxt;
      cooldown_r    <= cooldown_nxt;
      repeat_r      <= repeat_nxt;
      seq_step_r    <= seq_step_nxt;
      seq_done_r    <= seq_done_nxt;
      seq_refresh_r <= seq_refresh_nxt;
      ign_prev_r    <= ign_prev_nxt;
      brake_r       <= brake_nxt;
      ac_r          <= ac_nxt;
      asc_r         <= asc_nxt;
      meter_r       <= meter_nxt;
    end
  end

  `DCFS_ASSERT(a_refresh_step_range, seq_refresh_r |-> seq_step_r <= STEP_REF_END, "refresh sequence step out of range")
  `DCFS_ASSERT(a_init_step_range, !seq_refresh_r |-> seq_step_r <= STEP_INI_END, "init sequence step out of range")

endmodule

// File: hdl/dcfs_queue.sv
// short descriptor queue between front and back ends
// depends on dcfs_pkg for desc_t
`timescale 1ns / 1ps
`include "dash_can_frame_scheduler_macros.svh"

module dcfs_queue #(
  parameter int DEPTH = dcfs_pkg::DCFS_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dcfs_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dcfs_pkg::desc_t head_desc
);
  import dcfs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DCFS_ASSERT_NEVER(a_count_bound, count_r > CW'(DEPTH), "queue fill count above depth")
  `DCFS_ASSERT(a_push_when_full, full && !pop |=> count_r == CW'(DEPTH), "queue lost an entry while full")

endmodule

// File: hdl/dcfs_back.sv
// back end: expands one descriptor into its frames, one beat per cycle unless out_ready stalls
// depends on dcfs_pkg; output register decouples the result channel
`timescale 1ns / 1ps
`include "dash_can_frame_scheduler_macros.svh"

module dcfs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  dcfs_pkg::desc_t head_desc,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_frame_valid,
  output logic [10:0]     out_tx_id,
  output logic [63:0]     out_tx_payload,
  output logic            out_last,
  output logic            out_ac_request,
  output logic            out_brake_pressed,
  output logic            out_asc_active,
  output logic [7:0]      out_meter_status
);
  import dcfs_pkg::*;

  localparam logic [10:0] ID_101 = 11'h101;
  localparam logic [10:0] ID_111 = 11'h111;
  localparam logic [10:0] ID_1E1 = 11'h1E1;
  localparam logic [10:0] ID_210 = 11'h210;
  localparam logic [10:0] ID_212 = 11'h212;
  localparam logic [10:0] ID_308 = 11'h308;
  localparam logic [10:0] ID_312 = 11'h312;
  localparam logic [10:0] ID_416 = 11'h416;
  localparam logic [10:0] ID_608 = 11'h608;

  logic [NSLOT-1:0]  sent_r, sent_nxt;
  logic [NSLOT-1:0]  remaining;
  logic [NSLOT-1:0]  sel_bit;
  logic [SLOT_W-1:0] sel;
  logic              is_last;
  logic              emit;
  logic              fv;
  logic [10:0]       id;
  logic [63:0]       payload;

  logic        out_valid_r;
  logic        out_frame_valid_r;
  logic [10:0] out_tx_id_r;
  logic [63:0] out_tx_payload_r;
  logic        out_last_r;
  logic        out_ac_r;
  logic        out_brake_r;
  logic        out_asc_r;
  logic [7:0]  out_meter_r;

  assign remaining = head_desc.mask & ~sent_r;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (remaining[i]) sel = SLOT_W'(i);
    end
  end

  assign sel_bit = NSLOT'(1) << sel;
  assign is_last = (remaining & ~sel_bit) == '0;
  assign emit    = head_valid && (!out_valid_r || out_ready);
  assign pop     = emit && is_last;

  always_comb begin
    sent_nxt = sent_r;
    if (emit) sent_nxt = is_last ? '0 : (sent_r | sel_bit);
  end

  always_comb begin
    fv      = 1'b1;
    id      = '0;
    payload = '0;
    if (remaining == '0) begin
      fv = 1'b0;
    end else begin
      case (sel)
        SLOT_W'(SLOT_SEQ): begin
          case (head_desc.seq_kind)
            SEQ_101_PRI: begin
              id      = ID_101;
              payload = 64'h009A_7807_875E_0092;
            end
            SEQ_101_FF: begin
              id      = ID_101;
              payload = 64'hFF00_0000_0000_0000;
            end
            default: begin
              id      = ID_111;
              payload = 64'h000B_0CEE_0000_0000;
            end
          endcase
        end
        SLOT_W'(SLOT_BRST0), SLOT_W'(SLOT_BRST1),
        SLOT_W'(SLOT_BRST2), SLOT_W'(SLOT_BRST3): begin
          id = ID_1E1;
        end
        SLOT_W'(SLOT_210): begin
          id      = ID_210;
          payload = {16'h0000, 7'd0, head_desc.lamp_210, 8'h40, 24'h000000, 8'hFF};
        end
        SLOT_W'(SLOT_212): begin
          id      = ID_212;
          payload = {8'h05, head_desc.b1_212, 16'h0000, 8'h68, head_desc.b5_212, 16'h0000};
        end
        SLOT_W'(SLOT_308): begin
          id      = ID_308;
          payload = {8'h80, head_desc.rpm_code, head_desc.b3_308, 7'd0, head_desc.b4_308,
                     head_desc.running ? 8'h53 : 8'h3E, 8'hFF, 8'h00};
        end
        SLOT_W'(SLOT_312): begin
          id      = ID_312;
          payload = head_desc.running ? 64'h07ED_07ED_0958_079F : 64'h0771_0771_0902_0791;
        end
        SLOT_W'(SLOT_416): begin
          id      = ID_416;
          payload = {head_desc.running ? 8'h8E : 8'h75, 56'd0};
        end
        SLOT_W'(SLOT_608): begin
          id      = ID_608;
          payload = head_desc.fan_hot ? 64'h6600_18C3_FF00_6500 : 64'h3400_18C3_FF00_0000;
        end
        default: begin
          fv = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame_valid_r <= fv;
      out_tx_id_r       <= id;
      out_tx_payload_r  <= payload;
      out_last_r        <= is_last;
      out_ac_r          <= head_desc.ac;
      out_brake_r       <= head_desc.brake;
      out_asc_r         <= head_desc.asc;
      out_meter_r       <= head_desc.meter;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_valid   = out_frame_valid_r;
  assign out_tx_id         = out_tx_id_r;
  assign out_tx_payload    = out_tx_payload_r;
  assign out_last          = out_last_r;
  assign out_ac_request    = out_ac_r;
  assign out_brake_pressed = out_brake_r;
  assign out_asc_active    = out_asc_r;
  assign out_meter_status  = out_meter_r;

  `DCFS_ASSERT(a_status_is_last, out_valid && !out_frame_valid |-> out_last, "status beat not marked last")

endmodule

// File: hdl/dash_can_frame_scheduler.sv
// Dashboard CAN frame scheduler. Each input beat is a 5 ms tick or a received
// CAN frame; the block answers it with 1 to 11 result beats (up to 11 on a
// tick that carries a sequence frame, a clear burst and both periodic slots,
// at most 3 on a received frame), the last one flagged by out_last. An event
// that sends nothing yields a single status beat with out_frame_valid low.
// The front end takes one beat per cycle while the queue has room and settles
// all state in that cycle; the back end then emits one result per cycle from
// the queue while out_ready does not stall it, so an event with N results
// gives N result beats, which pass through the queue and the output register.
// in_ready drops only when the descriptor queue (QUEUE_DEPTH events) is full.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant for idle periods; there is no clearing pass after reset.
// Depends on dcfs_pkg, dcfs_front, dcfs_queue and dcfs_back.
`timescale 1ns / 1ps

module dash_can_frame_scheduler #(
  parameter int QUEUE_DEPTH = dcfs_pkg::DCFS_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dcfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic                            in_slot_20ms,
  input  logic                            in_slot_100ms,
  input  logic                            in_ignition_on,
  input  logic [15:0]                     in_engine_rpm,
  input  logic signed [12:0]              in_coolant_tenths,
  input  logic [10:0]                     in_rx_id,
  input  logic [3:0]                      in_rx_dlc,
  input  logic [7:0]                      in_rx_byte0,
  input  logic [7:0]                      in_rx_byte1,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_frame_valid,
  output logic [10:0]                     out_tx_id,
  output logic [63:0]                     out_tx_payload,
  output logic                            out_last,
  output logic                            out_ac_request,
  output logic                            out_brake_pressed,
  output logic                            out_asc_active,
  output logic [7:0]                      out_meter_status
);
  import dcfs_pkg::*;

  logic  q_full;
  logic  q_push;
  desc_t q_push_desc;
  logic  q_pop;
  logic  q_head_valid;
  desc_t q_head_desc;

  dcfs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_slot_20ms      (in_slot_20ms),
    .in_slot_100ms     (in_slot_100ms),
    .in_ignition_on    (in_ignition_on),
    .in_engine_rpm     (in_engine_rpm),
    .in_coolant_tenths (in_coolant_tenths),
    .in_rx_id          (in_rx_id),
    .in_rx_dlc         (in_rx_dlc),
    .in_rx_byte0       (in_rx_byte0),
    .in_rx_byte1       (in_rx_byte1),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_desc            (q_push_desc)
  );

  dcfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc)
  );

  dcfs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_desc         (q_head_desc),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_valid   (out_frame_valid),
    .out_tx_id         (out_tx_id),
    .out_tx_payload    (out_tx_payload),
    .out_last          (out_last),
    .out_ac_request    (out_ac_request),
    .out_brake_pressed (out_brake_pressed),
    .out_asc_active    (out_asc_active),
    .out_meter_status  (out_meter_status)
  );

endmodule

// File: test/tb.sv
// Self-checking testbench for dash_can_frame_scheduler: tick and CAN rx beats go in,
// every result beat is checked against a cycle-free model of the frame schedule.
// Depends on dcfs_pkg and the dash_can_frame_scheduler RTL.
`timescale 1ns / 1ps

module tb;
  import dcfs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 42;
  localparam int DRAIN       = 16;

  localparam bit FUNC_TICK = 1'b0;
  localparam bit FUNC_RX   = 1'b1;

  localparam logic [10:0] ID_START     = 11'h002;
  localparam logic [10:0] ID_101       = 11'h101;
  localparam logic [10:0] ID_111       = 11'h111;
  localparam logic [10:0] ID_CLEAR     = 11'h1E1;
  localparam logic [10:0] ID_BRAKE     = 11'h200;
  localparam logic [10:0] ID_210       = 11'h210;
  localparam logic [10:0] ID_212       = 11'h212;
  localparam logic [10:0] ID_CLEAR_REQ = 11'h2F1;
  localparam logic [10:0] ID_ASC       = 11'h300;
  localparam logic [10:0] ID_308       = 11'h308;
  localparam logic [10:0] ID_312       = 11'h312;
  localparam logic [10:0] ID_METER     = 11'h412;
  localparam logic [10:0] ID_416       = 11'h416;
  localparam logic [10:0] ID_AC        = 11'h443;
  localparam logic [10:0] ID_608       = 11'h608;
  localparam logic [7:0]  CLEAR_KEY    = 8'h81;

  typedef struct {
    bit                 func;
    bit                 s20;
    bit                 s100;
    bit                 ign;
    logic [15:0]        rpm;
    logic signed [12:0] clt;
    logic [10:0]        rx_id;
    logic [3:0]         dlc;
    logic [7:0]         d0;
    logic [7:0]         d1;
  } event_t;

  typedef struct packed {
    logic        fv;
    logic [10:0] id;
    logic [63:0] payload;
    logic        last;
    logic        ac;
    logic        brake;
    logic        asc;
    logic [7:0]  meter;
  } result_t;

  typedef struct {
    logic [10:0] id;
    logic [63:0] payload;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic in_func, in_slot_20ms, in_slot_100ms, in_ignition_on;
  logic [15:0] in_engine_rpm;
  logic signed [12:0] in_coolant_tenths;
  logic [10:0] in_rx_id;
  logic [3:0] in_rx_dlc;
  logic [7:0] in_rx_byte0, in_rx_byte1;
  logic out_valid, out_ready;
  logic out_frame_valid;
  logic [10:0] out_tx_id;
  logic [63:0] out_tx_payload;
  logic out_last, out_ac_request, out_brake_pressed, out_asc_active;
  logic [7:0] out_meter_status;

  dash_can_frame_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_slot_20ms(in_slot_20ms), .in_slot_100ms(in_slot_100ms),
    .in_ignition_on(in_ignition_on), .in_engine_rpm(in_engine_rpm),
    .in_coolant_tenths(in_coolant_tenths), .in_rx_id(in_rx_id), .in_rx_dlc(in_rx_dlc),
    .in_rx_byte0(in_rx_byte0), .in_rx_byte1(in_rx_byte1),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_valid(out_frame_valid), .out_tx_id(out_tx_id),
    .out_tx_payload(out_tx_payload), .out_last(out_last),
    .out_ac_request(out_ac_request), .out_brake_pressed(out_brake_pressed),
    .out_asc_active(out_asc_active), .out_meter_status(out_meter_status)
  );

  always #6 clk = ~clk;

  // model registers
  logic [15:0]        c_running_rpm = 16'd400;
  logic signed [12:0] c_fan_hot     = 13'sd950;
  logic [15:0]        c_bulb        = 16'd200;
  logic [15:0]        c_settle      = 16'd250;
  logic [7:0]         c_burst       = 8'd200;
  logic [7:0]         c_cooldown    = 8'd200;
  logic [11:0]        c_repeat      = 12'd1500;

  // model state
  logic [15:0] ign_ticks = '0;
  logic [7:0]  burst_cnt = '0;
  logic [7:0]  cool_cnt = '0;
  logic [11:0] rep_cnt = '0;
  logic [4:0]  seq_pos = '0;
  bit          seq_finished = 0, seq_refresh = 0, ign_last = 0;
  bit          brake_s = 0, ac_s = 0, asc_s = 0;
  logic [7:0]  meter_s = '0;

  event_t  event_q[$];
  event_t  cur_ev;
  frame_t  ev_frames[$];
  result_t due_frames[$];
  bit      in_beat_taken = 0;
  int      err_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  task automatic add_frame(input logic [10:0] id, input logic [63:0] payload);
    frame_t f;
    f.id = id;
    f.payload = payload;
    if (ev_frames.size() < NSLOT) ev_frames.push_back(f);
  endtask

  task automatic seq_begin(input bit refresh);
    if (seq_pos == 0) begin
      seq_refresh = refresh;
      seq_pos = 5'd1;
    end
  endtask

  task automatic seq_tick();
    if (seq_pos != 0) begin
      if (seq_refresh) begin
        case (seq_pos)
          5'd1: add_frame(ID_101, 64'h009A_7807_875E_0092);
          5'd4: add_frame(ID_111, 64'h000B_0CEE_0000_0000);
          5'd5: add_frame(ID_101, 64'hFF00_0000_0000_0000);
          5'd8: begin
            add_frame(ID_111, 64'h000B_0CEE_0000_0000);
            seq_pos = 0;
          end
          default: ;
        endcase
      end else begin
        case (seq_pos)
          5'd10: add_frame(ID_101, 64'h009A_7807_875E_0092);
          5'd13: add_frame(ID_111, 64'h000B_0CEE_0000_0000);
          5'd14: add_frame(ID_101, 64'hFF00_0000_0000_0000);
          5'd15: begin
            add_frame(ID_111, 64'h000B_0CEE_0000_0000);
            seq_finished = 1;
            seq_pos = 0;
          end
          default: ;
        endcase
      end
      if (seq_pos != 0) seq_pos = seq_pos + 5'd1;
    end
  endtask

  task automatic slot_20_frames(input logic [15:0] rpm, input bit running);
    logic [7:0]  b1, b5, b3;
    logic        b4;
    logic [31:0] raw;
    logic [15:0] code;
    add_frame(ID_210, {16'h0, 7'b0, (!running && ign_ticks <= 16'd1), 8'h40, 24'h0, 8'hFF});
    if (!running) begin b1 = 8'h37; b5 = 8'hDA; end
    else if (rpm >= 16'd1500) begin b1 = 8'h20; b5 = 8'h2F; end
    else if (rpm >= 16'd1200) begin b1 = 8'h28; b5 = 8'h31; end
    else if (rpm >= 16'd1000) begin b1 = 8'h37; b5 = 8'h34; end
    else if (rpm >= 16'd900) begin b1 = 8'h37; b5 = 8'h37; end
    else begin b1 = 8'h37; b5 = 8'h3A; end
    add_frame(ID_212, {8'h05, b1, 16'h0, 8'h68, b5, 16'h0});
    raw = ({16'h0, rpm} * 32'd1024 + 32'd500) / 32'd1000;
    code = (raw > 32'hFFFF) ? 16'hFFFF : raw[15:0];
    if (running) begin
      add_frame(ID_308, {8'h80, code, 16'h0, 8'h53, 8'hFF, 8'h00});
      add_frame(ID_312, 64'h07ED_07ED_0958_079F);
    end else begin
      if (ign_ticks <= c_bulb) begin
        b3 = 8'h06;
        b4 = 1'b1;
      end else begin
        b3 = 8'h04;
        b4 = (ign_ticks <= c_settle);
      end
      add_frame(ID_308, {8'h80, code, b3, 7'b0, b4, 8'h3E, 8'hFF, 8'h00});
      add_frame(ID_312, 64'h0771_0771_0902_0791);
    end
  endtask

  task automatic run_tick(input event_t ev);
    bit running;
    running = ev.rpm > c_running_rpm;
    seq_tick();
    if (burst_cnt != 0) begin
      repeat (4) add_frame(ID_CLEAR, 64'h0);
      burst_cnt = burst_cnt - 8'd1;
    end
    if (cool_cnt != 0) cool_cnt = cool_cnt - 8'd1;
    if (!ev.ign) begin
      if (ign_last && seq_pos == 0) seq_finished = 0;
      ign_last = 0;
      ign_ticks = '0;
      rep_cnt = '0;
    end else begin
      if (!ign_last) seq_begin(0);
      ign_last = 1;
      if (ev.s20) begin
        if (ign_ticks != 16'hFFFF) ign_ticks = ign_ticks + 16'd1;
        if (rep_cnt != 12'hFFF) rep_cnt = rep_cnt + 12'd1;
        if (rep_cnt >= c_repeat) begin
          seq_begin(1);
          rep_cnt = '0;
        end
        slot_20_frames(ev.rpm, running);
      end
      if (ev.s100) begin
        add_frame(ID_416, {(running ? 8'h8E : 8'h75), 56'h0});
        if (running || ev.clt >= c_fan_hot) add_frame(ID_608, 64'h6600_18C3_FF00_6500);
        else add_frame(ID_608, 64'h3400_18C3_FF00_0000);
      end
    end
  endtask

  task automatic run_rx(input event_t ev);
    if (ev.rx_id == ID_START && ev.dlc >= 4'd2 && ev.d0 == 8'h00 && ev.d1 == 8'h00 &&
        !seq_finished && seq_pos == 0)
      seq_begin(0);
    if (ev.rx_id == ID_CLEAR && ev.dlc > 4'd0 && ev.d0 == CLEAR_KEY) begin
      burst_cnt = c_burst;
      repeat (3) add_frame(ID_CLEAR, 64'h0);
    end
    if (ev.rx_id == ID_CLEAR_REQ && ev.dlc >= 4'd2 && ev.d0 == 8'h00 && ev.d1 == CLEAR_KEY &&
        cool_cnt == 0) begin
      repeat (3) add_frame(ID_CLEAR, 64'h0);
      cool_cnt = c_cooldown;
    end
    if (ev.rx_id == ID_BRAKE && ev.dlc > 4'd1) brake_s = (ev.d1 & 8'h05) == 8'h05;
    else if (ev.rx_id == ID_ASC && ev.dlc > 4'd0) asc_s = ev.d0[7];
    else if (ev.rx_id == ID_METER && ev.dlc > 4'd0) meter_s = ev.d0;
    else if (ev.rx_id == ID_AC && ev.dlc > 4'd0) ac_s = ev.d0[0];
  endtask

  task automatic schedule_event(input event_t ev);
    result_t r;
    ev_frames.delete();
    if (ev.func == FUNC_RX) run_rx(ev);
    else run_tick(ev);
    r.ac = ac_s;
    r.brake = brake_s;
    r.asc = asc_s;
    r.meter = meter_s;
    if (ev_frames.size() == 0) begin
      r.fv = 1'b0;
      r.id = '0;
      r.payload = '0;
      r.last = 1'b1;
      due_frames.push_back(r);
    end else begin
      foreach (ev_frames[k]) begin
        r.fv = 1'b1;
        r.id = ev_frames[k].id;
        r.payload = ev_frames[k].payload;
        r.last = (k == ev_frames.size() - 1);
        due_frames.push_back(r);
      end
    end
  endtask

  function automatic string fmt_result(input result_t r);
    return $sformatf("fv=%0b id=%h payload=%h last=%0b ac=%0b brake=%0b asc=%0b meter=%h",
                     r.fv, r.id, r.payload, r.last, r.ac, r.brake, r.asc, r.meter);
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch %0d: %s", err_count, msg);
  endtask

  function automatic event_t tick_ev(input bit ign, input bit s20, input bit s100,
                                     input int rpm, input int clt);
    event_t ev;
    ev.func = FUNC_TICK;
    ev.s20 = s20;
    ev.s100 = s100;
    ev.ign = ign;
    ev.rpm = rpm[15:0];
    ev.clt = clt[12:0];
    ev.rx_id = $urandom_range(0, 2047);
    ev.dlc = $urandom_range(0, 15);
    ev.d0 = $urandom_range(0, 255);
    ev.d1 = $urandom_range(0, 255);
    return ev;
  endfunction

  function automatic event_t rx_ev(input int id, input int dlc, input int d0, input int d1);
    event_t ev;
    ev.func = FUNC_RX;
    ev.s20 = $urandom_range(0, 1);
    ev.s100 = $urandom_range(0, 1);
    ev.ign = $urandom_range(0, 1);
    ev.rpm = $urandom_range(0, 65535);
    ev.clt = $urandom_range(0, 8191);
    ev.rx_id = id[10:0];
    ev.dlc = dlc[3:0];
    ev.d0 = d0[7:0];
    ev.d1 = d1[7:0];
    return ev;
  endfunction

  // mostly a well-formed 5 ms tick stream with occasional ignition drops,
  // interleaved with rx frames aimed at the decoded ids, plus some noise
  task automatic gen_phase(input int n);
    int t, r, rpm, clt, id, dlc, d0, d1;
    bit ign;
    t = $urandom_range(0, 19);
    ign = 1;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: rpm = $urandom_range(0, 65535);
        1: rpm = $urandom_range(0, 2000);
        2: rpm = c_running_rpm + $urandom_range(0, 2) - 1;
        default: rpm = 900 + 100 * $urandom_range(0, 6) - $urandom_range(0, 1);
      endcase
      if ($urandom_range(0, 1)) clt = $urandom_range(0, 2550) - 400;
      else clt = int'(c_fan_hot) + $urandom_range(0, 2) - 1;
      if (clt < -400) clt = -400;
      if (clt > 2150) clt = 2150;
      if (r < 68) begin
        t++;
        if ($urandom_range(0, 99) < 4) ign = 0;
        else if (!ign && $urandom_range(0, 99) < 40) ign = 1;
        event_q.push_back(tick_ev(ign, (t % 4) == 0, (t % 8) == 0, rpm, clt));
      end else if (r < 92) begin
        case ($urandom_range(0, 8))
          0: id = ID_START;
          1: id = ID_CLEAR;
          2: id = ID_CLEAR_REQ;
          3: id = ID_BRAKE;
          4: id = ID_ASC;
          5: id = ID_METER;
          6: id = ID_AC;
          default: id = $urandom_range(0, 2047);
        endcase
        dlc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        case ($urandom_range(0, 4))
          0: d0 = 8'h00;
          1: d0 = CLEAR_KEY;
          2: d0 = 8'h80;
          3: d0 = 8'h01;
          default: d0 = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 3))
          0: d1 = 8'h00;
          1: d1 = CLEAR_KEY;
          2: d1 = 8'h05;
          default: d1 = $urandom_range(0, 255);
        endcase
        event_q.push_back(rx_ev(id, dlc, d0, d1));
      end else begin
        event_q.push_back(tick_ev($urandom_range(0, 1), $urandom_range(0, 1),
                                  $urandom_range(0, 1), $urandom_range(0, 65535),
                                  $urandom_range(0, 2550) - 400));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_RUNNING_RPM: c_running_rpm = val[15:0];
      CFG_FAN_HOT:     c_fan_hot = val[12:0];
      CFG_BULB_CHECK:  c_bulb = val[15:0];
      CFG_SETTLE:      c_settle = val[15:0];
      CFG_BURST:       c_burst = val[7:0];
      CFG_COOLDOWN:    c_cooldown = val[7:0];
      CFG_REPEAT:      c_repeat = val[11:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input int running, input int fan, input int bulb, input int settle,
                          input int burst, input int cooldown, input int rep);
    write_reg(CFG_RUNNING_RPM, running);
    write_reg(CFG_FAN_HOT, fan);
    write_reg(CFG_BULB_CHECK, bulb);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_BURST, burst);
    write_reg(CFG_COOLDOWN, cooldown);
    write_reg(CFG_REPEAT, rep);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle(input int extra);
    @(negedge clk);
    while (event_q.size() != 0 || in_valid || due_frames.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_beat_taken)) begin
      if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_ev = event_q.pop_front();
        in_valid <= 1'b1;
        in_func <= cur_ev.func;
        in_slot_20ms <= cur_ev.s20;
        in_slot_100ms <= cur_ev.s100;
        in_ignition_on <= cur_ev.ign;
        in_engine_rpm <= cur_ev.rpm;
        in_coolant_tenths <= cur_ev.clt;
        in_rx_id <= cur_ev.rx_id;
        in_rx_dlc <= cur_ev.dlc;
        in_rx_byte0 <= cur_ev.d0;
        in_rx_byte1 <= cur_ev.d1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_beat_taken = 0;
  end

  // result receiver
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // monitor and checker
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_frame_valid, out_tx_id, out_tx_payload, out_last, out_ac_request,
               out_brake_pressed, out_asc_active, out_meter_status};
        if (due_frames.size() == 0) begin
          report({"unexpected beat: ", fmt_result(got)});
        end else begin
          want = due_frames.pop_front();
          if (got !== want)
            report({"expected ", fmt_result(want), " got ", fmt_result(got)});
        end
      end
      if (in_valid && in_ready) begin
        schedule_event(cur_ev);
        in_beat_taken = 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_slot_20ms = 1'b0;
    in_slot_100ms = 1'b0;
    in_ignition_on = 1'b0;
    in_engine_rpm = '0;
    in_coolant_tenths = '0;
    in_rx_id = '0;
    in_rx_dlc = '0;
    in_rx_byte0 = '0;
    in_rx_byte1 = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 55;
    set_regs(1000, 0, 1, 3, 12, 3, 1);
    // directed: start request, busy start, clears, lockout, decoded ids, long dlc
    event_q.push_back(tick_ev(0, 1, 1, 0, -400));
    event_q.push_back(rx_ev(ID_START, 2, 8'h00, 8'h00));
    event_q.push_back(rx_ev(ID_START, 8, 8'h00, 8'h00));
    event_q.push_back(rx_ev(ID_CLEAR, 1, CLEAR_KEY, 8'h00));
    event_q.push_back(rx_ev(ID_CLEAR_REQ, 2, 8'h00, CLEAR_KEY));
    event_q.push_back(rx_ev(ID_CLEAR_REQ, 2, 8'h00, CLEAR_KEY));
    event_q.push_back(rx_ev(ID_BRAKE, 2, 8'h00, 8'h05));
    event_q.push_back(rx_ev(ID_ASC, 9, 8'h80, 8'h00));
    event_q.push_back(rx_ev(ID_METER, 15, 8'hFF, 8'h00));
    event_q.push_back(rx_ev(ID_AC, 1, 8'h01, 8'h00));
    event_q.push_back(rx_ev(ID_BRAKE, 1, 8'h00, 8'hFF));
    event_q.push_back(rx_ev(2047, 0, 8'hFF, 8'hFF));
    // ignition on with sequence, burst and both slots overlapping
    for (int k = 0; k < 12; k++) begin
      int rpm, clt;
      case (k)
        0: rpm = 0;
        1: rpm = 1000;
        2: rpm = 1001;
        3: rpm = 899;
        4: rpm = 900;
        5: rpm = 1199;
        6: rpm = 1200;
        7: rpm = 1499;
        8: rpm = 1500;
        9: rpm = 65535;
        10: rpm = 64000;
        default: rpm = 2000;
      endcase
      case (k % 4)
        0: clt = -400;
        1: clt = -1;
        2: clt = 0;
        default: clt = 2150;
      endcase
      event_q.push_back(tick_ev(1, 1, 1, rpm, clt));
    end
    event_q.push_back(tick_ev(0, 0, 0, 65535, 2150));
    wait_idle(DRAIN);

    set_regs(400, 950, 4, 8, 3, 5, 6);
    gen_phase(RAND_ITEMS);
    wait_idle(DRAIN);

    send_idle_pct = 55;
    recv_idle_pct = 7;
    set_regs(0, -400, 0, 0, 255, 255, 0);
    gen_phase(RAND_ITEMS);
    wait_idle(DRAIN);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(65535, 2150, 65534, 65534, 0, 0, 4095);
    gen_phase(RAND_ITEMS);
    wait_idle(DRAIN);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/dcfs_pkg.sv
hdl/dcfs_front.sv
hdl/dcfs_queue.sv
hdl/dcfs_back.sv
hdl/dash_can_frame_scheduler.sv
test/tb.sv
